[sv/cmb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmb_pkg
// Shared constants, codes and controller/datapath handshake types for the
// cluster membership bookkeeper.
// ----------------------------------------------------------------------------
package cmb_pkg;

  localparam int MAX_GROUPS_DEF   = 256;
  localparam int MAX_FEATURES_DEF = 32;

  localparam int GROUP_W = 8;   // group and target class fields
  localparam int BITS_W  = 32;  // feature bits field
  localparam int OUT_W   = 9;   // class and count result fields
  localparam int GIU_W   = 9;   // groups_in_use register
  localparam int FIU_W   = 6;   // features_in_use register
  localparam int CFG_W   = 9;   // config write data
  localparam int SUM_W   = 9;   // one per-class feature sum

  localparam logic [GIU_W-1:0] GIU_RESET = 9'd256;
  localparam logic [FIU_W-1:0] FIU_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_MOVE   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic {
    REG_GROUPS   = 1'b0,
    REG_FEATURES = 1'b1
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;  // clearing pass, one row per cycle
    logic accept;      // capture the input item
    logic rd_prev;     // read count/sum rows of the old class
    logic upd_prev;    // write back the old class
    logic upd_tgt;     // write back the new class, group row and result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

[sv/cmb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/cmb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmb_ctrl
// Sequencer: clearing pass after reset, then accept / read old class /
// write old class / write new class and result for each item.
// ----------------------------------------------------------------------------
module cmb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cmb_pkg::sts_t sts,
  output cmb_pkg::cmd_t cmd
);
  import cmb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_PREV,
    S_WR_PREV,
    S_WR_TGT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR:   if (sts.clear_done) state <= S_IDLE;
        S_IDLE:    if (in_valid) state <= S_RD_PREV;
        S_RD_PREV: state <= S_WR_PREV;
        S_WR_PREV: state <= S_WR_TGT;
        S_WR_TGT:  if (!sts.out_busy) state <= S_IDLE;
        default:   state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    in_ready       = (state == S_IDLE);
    cmd.clear_step = (state == S_CLEAR);
    cmd.accept     = (state == S_IDLE) && in_valid;
    cmd.rd_prev    = (state == S_RD_PREV);
    cmd.upd_prev   = (state == S_WR_PREV);
    // hold here until the result register is free
    cmd.upd_tgt    = (state == S_WR_TGT) && !sts.out_busy;
  end

endmodule
`default_nettype wire

[sv/cmb_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmb_datapath
// Config registers, the four state memories, occupied-class counter,
// feature-sum lane arithmetic and the result register.
// ----------------------------------------------------------------------------
module cmb_datapath #(
  parameter int MAX_GROUPS   = cmb_pkg::MAX_GROUPS_DEF,
  parameter int MAX_FEATURES = cmb_pkg::MAX_FEATURES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmb_pkg::cmd_t                cmd,
  output cmb_pkg::sts_t                sts,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [cmb_pkg::CFG_W-1:0]    cfg_data,
  input  logic [1:0]                   opcode,
  input  logic [cmb_pkg::GROUP_W-1:0]  group,
  input  logic [cmb_pkg::GROUP_W-1:0]  target_class,
  input  logic [cmb_pkg::BITS_W-1:0]   feature_bits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic [cmb_pkg::OUT_W-1:0]    previous_class,
  output logic [cmb_pkg::OUT_W-1:0]    class_members,
  output logic [cmb_pkg::OUT_W-1:0]    nonempty_classes
);
  import cmb_pkg::*;

  localparam int AW = $clog2(MAX_GROUPS);
  localparam int CW = $clog2(MAX_GROUPS + 1);  // class code incl. unassigned, counts
  localparam int FW = MAX_FEATURES;
  localparam int RW = FW * SUM_W;
  localparam logic [CW-1:0] UNASSIGNED = CW'(MAX_GROUPS);

  // config
  logic [GIU_W-1:0] giu;
  logic [FIU_W-1:0] fiu;

  // item registers
  op_t             op_r;
  logic [GROUP_W-1:0] grp_r;
  logic [GROUP_W-1:0] tgt_r;
  logic [FW-1:0]   bits_r;
  logic            in_range_r;
  logic [CW-1:0]   prev_r;
  logic [FW-1:0]   old_r;
  logic [CW-1:0]   tsize_r;
  logic [RW-1:0]   trow_r;
  logic [CW-1:0]   psize_r;
  logic [CW-1:0]   occ;
  logic [CW-1:0]   clr_cnt;

  // memory ports
  logic          cog_we, gft_we, csz_we, cfs_we;
  logic [AW-1:0] cog_waddr, gft_waddr, csz_waddr, cfs_waddr;
  logic [CW-1:0] cog_wdata, cog_rd;
  logic [FW-1:0] gft_wdata, gft_rd;
  logic [CW-1:0] csz_wdata, csz_rd;
  logic [RW-1:0] cfs_wdata, cfs_rd;
  logic [AW-1:0] row_raddr;

  // decode
  op_t           op_in;
  logic          g_ok, t_ok, in_range;
  logic [FW-1:0] fmask;
  logic          assigned, same, do_leave, do_reload, do_join;
  logic [CW-1:0] pdec;
  logic          leave_empties, join_fills;
  logic [RW-1:0] prow_new, trow_new;
  logic [CW-1:0] members;

  assign op_in    = op_t'(opcode);
  assign g_ok     = (GIU_W'(group) < giu) && (32'(group) < 32'(MAX_GROUPS));
  assign t_ok     = (GIU_W'(target_class) < giu) && (32'(target_class) < 32'(MAX_GROUPS));
  assign in_range = g_ok && ((op_in != OP_MOVE) || t_ok);

  assign sts.clear_done = (clr_cnt == UNASSIGNED);
  assign sts.out_busy   = out_valid && !out_ready;

  always_comb begin
    for (int i = 0; i < FW; i++) begin
      fmask[i] = (int'(fiu) > i);
    end
  end

  assign assigned  = (prev_r < UNASSIGNED);
  assign same      = assigned && (prev_r == CW'(tgt_r));
  assign do_leave  = in_range_r && assigned &&
                     (((op_r == OP_MOVE) && !same) || (op_r == OP_REMOVE));
  assign do_reload = in_range_r && assigned && (op_r == OP_LOAD);
  assign do_join   = in_range_r && (op_r == OP_MOVE) && !same;

  // csz_rd holds the old class size during the write-back of the old class
  assign pdec          = (csz_rd != '0) ? (csz_rd - CW'(1)) : '0;
  assign leave_empties = do_leave && (csz_rd != '0) && (pdec == '0) && (occ != '0);
  assign join_fills    = do_join && (tsize_r == '0);

  // per-feature lanes, all features of a row in parallel
  always_comb begin
    for (int i = 0; i < FW; i++) begin
      prow_new[i*SUM_W +: SUM_W] = cfs_rd[i*SUM_W +: SUM_W]
                                   - SUM_W'(old_r[i] & fmask[i])
                                   + SUM_W'(do_reload & bits_r[i] & fmask[i]);
      trow_new[i*SUM_W +: SUM_W] = trow_r[i*SUM_W +: SUM_W]
                                   + SUM_W'(old_r[i] & fmask[i]);
    end
  end

  always_comb begin
    if (!in_range_r) begin
      members = '0;
    end else if (op_r == OP_MOVE) begin
      members = tsize_r + CW'(!same);
    end else begin
      members = psize_r;
    end
  end

  // memory write/read muxing
  always_comb begin
    cog_we    = 1'b0;
    cog_waddr = AW'(grp_r);
    cog_wdata = UNASSIGNED;
    gft_we    = 1'b0;
    gft_waddr = AW'(grp_r);
    gft_wdata = bits_r;
    csz_we    = 1'b0;
    csz_waddr = AW'(prev_r);
    csz_wdata = pdec;
    cfs_we    = 1'b0;
    cfs_waddr = AW'(prev_r);
    cfs_wdata = prow_new;
    if (cmd.clear_step) begin
      cog_we    = !sts.clear_done;
      cog_waddr = AW'(clr_cnt);
      gft_we    = !sts.clear_done;
      gft_waddr = AW'(clr_cnt);
      gft_wdata = '0;
      csz_we    = !sts.clear_done;
      csz_waddr = AW'(clr_cnt);
      csz_wdata = '0;
      cfs_we    = !sts.clear_done;
      cfs_waddr = AW'(clr_cnt);
      cfs_wdata = '0;
    end else if (cmd.upd_prev) begin
      csz_we = do_leave;
      cfs_we = do_leave || do_reload;
    end else if (cmd.upd_tgt) begin
      if (in_range_r && (op_r == OP_MOVE)) begin
        cog_we    = 1'b1;
        cog_wdata = CW'(tgt_r);
      end else begin
        cog_we    = do_leave;
      end
      gft_we    = in_range_r && (op_r == OP_LOAD);
      csz_we    = do_join;
      csz_waddr = AW'(tgt_r);
      csz_wdata = tsize_r + CW'(1);
      cfs_we    = do_join;
      cfs_waddr = AW'(tgt_r);
      cfs_wdata = trow_new;
    end
  end

  assign row_raddr = cmd.rd_prev ? AW'(cog_rd) : AW'(target_class);

  cmb_ram #(.WIDTH(CW), .DEPTH(MAX_GROUPS)) u_cog (
    .clk(clk), .we(cog_we), .waddr(cog_waddr), .wdata(cog_wdata),
    .raddr(AW'(group)), .rdata(cog_rd)
  );

  cmb_ram #(.WIDTH(FW), .DEPTH(MAX_GROUPS)) u_gft (
    .clk(clk), .we(gft_we), .waddr(gft_waddr), .wdata(gft_wdata),
    .raddr(AW'(group)), .rdata(gft_rd)
  );

  cmb_ram #(.WIDTH(CW), .DEPTH(MAX_GROUPS)) u_csz (
    .clk(clk), .we(csz_we), .waddr(csz_waddr), .wdata(csz_wdata),
    .raddr(row_raddr), .rdata(csz_rd)
  );

  cmb_ram #(.WIDTH(RW), .DEPTH(MAX_GROUPS)) u_cfs (
    .clk(clk), .we(cfs_we), .waddr(cfs_waddr), .wdata(cfs_wdata),
    .raddr(row_raddr), .rdata(cfs_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      giu       <= GIU_RESET;
      fiu       <= FIU_RESET;
      occ       <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GROUPS:   giu <= cfg_data;
          REG_FEATURES: fiu <= cfg_data[FIU_W-1:0];
          default:      giu <= giu;
        endcase
      end
      if (cmd.clear_step && !sts.clear_done) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      if (cmd.upd_prev && leave_empties) begin
        occ <= occ - CW'(1);
      end else if (cmd.upd_tgt && join_fills) begin
        occ <= occ + CW'(1);
      end
      if (cmd.upd_tgt) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= op_in;
      grp_r      <= group;
      tgt_r      <= target_class;
      bits_r     <= FW'(feature_bits);
      in_range_r <= in_range;
    end
    if (cmd.rd_prev) begin
      prev_r  <= cog_rd;
      old_r   <= gft_rd;
      tsize_r <= csz_rd;
      trow_r  <= cfs_rd;
    end
    if (cmd.upd_prev) begin
      if (op_r == OP_REMOVE) begin
        psize_r <= do_leave ? pdec : '0;
      end else begin
        psize_r <= assigned ? csz_rd : '0;
      end
    end
    if (cmd.upd_tgt) begin
      status           <= !in_range_r;
      previous_class   <= in_range_r ? OUT_W'(prev_r) : OUT_W'(UNASSIGNED);
      class_members    <= OUT_W'(members);
      nonempty_classes <= OUT_W'(occ + CW'(join_fills));
    end
  end

endmodule
`default_nettype wire

[sv/cluster_membership_bookkeeper.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_membership_bookkeeper
// Class membership, class sizes, non-empty class count and per-class feature
// sums for a mixture-model clustering sampler.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all MAX_GROUPS rows
// (in_ready low, config writes still taken). Each item then goes through
// these steps from accept to result: accept and read the group's class and features, read
// the old class row, write back the old class, write back the new class with
// the group row and load the result register. The steps are set by the class
// size and feature-sum memories, which take one read and one write per
// cycle and must visit the old and the new class in turn. One item is in
// flight at a time; a finished result waits in the output register while
// the next item is accepted, and the last step stalls only if that register
// is still full. Every item gives exactly one result.
module cluster_membership_bookkeeper #(
  parameter int MAX_GROUPS   = cmb_pkg::MAX_GROUPS_DEF,
  parameter int MAX_FEATURES = cmb_pkg::MAX_FEATURES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [cmb_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [cmb_pkg::GROUP_W-1:0]  group,
  input  logic [cmb_pkg::GROUP_W-1:0]  target_class,
  input  logic [cmb_pkg::BITS_W-1:0]   feature_bits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic [cmb_pkg::OUT_W-1:0]    previous_class,
  output logic [cmb_pkg::OUT_W-1:0]    class_members,
  output logic [cmb_pkg::OUT_W-1:0]    nonempty_classes
);
  import cmb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cmb_datapath #(
    .MAX_GROUPS   (MAX_GROUPS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (opcode),
    .group            (group),
    .target_class     (target_class),
    .feature_bits     (feature_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .previous_class   (previous_class),
    .class_members    (class_members),
    .nonempty_classes (nonempty_classes)
  );

endmodule
`default_nettype wire

[sv/cmb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmb_checker
// Port-level checks for the cluster membership bookkeeper, bound to the top.
// ----------------------------------------------------------------------------
module cmb_checker #(
  parameter int MAX_GROUPS = cmb_pkg::MAX_GROUPS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         status,
  input logic [cmb_pkg::OUT_W-1:0]    previous_class,
  input logic [cmb_pkg::OUT_W-1:0]    class_members,
  input logic [cmb_pkg::OUT_W-1:0]    nonempty_classes
);
  import cmb_pkg::*;

  localparam logic [OUT_W-1:0] UNASSIGNED_OUT = OUT_W'(MAX_GROUPS);

  // clearing pass keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("in_ready high in the cycle after reset");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (previous_class == UNASSIGNED_OUT) && (class_members == '0))
    else $error("rejected item reports a class or a member count");

  a_members_occupied: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status && (class_members != '0) |-> (nonempty_classes != '0))
    else $error("members reported while no class is occupied");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(previous_class) && $stable(class_members) && $stable(nonempty_classes))
    else $error("result changed while stalled");

endmodule

bind cluster_membership_bookkeeper cmb_checker #(.MAX_GROUPS(MAX_GROUPS)) u_cmb_checker (.*);
`default_nettype wire

[tb/cluster_membership_bookkeeper_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_membership_bookkeeper_test
// Self-checking bench for the cluster membership bookkeeper. A queue of items
// feeds a bursty valid/ready driver. Each accepted item updates a local copy of
// class membership, class sizes and the non-empty class count. A monitor with
// its own stall pattern compares every result with the oldest prediction.
// Directed items come first, then random traffic under several settings of
// the group and feature registers.
// ----------------------------------------------------------------------------
module cluster_membership_bookkeeper_test;
  import cmb_pkg::*;

  localparam int NUM_GROUPS  = MAX_GROUPS_DEF;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_WAIT  = 12;

  typedef struct packed {
    op_t                op;
    logic [GROUP_W-1:0] group;
    logic [GROUP_W-1:0] target_class;
    logic [BITS_W-1:0]  feature_bits;
  } member_req_t;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] previous_class;
    logic [OUT_W-1:0] class_members;
    logic [OUT_W-1:0] nonempty_classes;
  } member_rsp_t;

  logic                clk;
  logic                rst          = 1'b1;
  logic                cfg_write    = 1'b0;
  logic                cfg_index    = REG_GROUPS;
  logic [CFG_W-1:0]    cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [1:0]          opcode       = OP_LOAD;
  logic [GROUP_W-1:0]  group        = '0;
  logic [GROUP_W-1:0]  target_class = '0;
  logic [BITS_W-1:0]   feature_bits = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                status;
  logic [OUT_W-1:0]    previous_class;
  logic [OUT_W-1:0]    class_members;
  logic [OUT_W-1:0]    nonempty_classes;

  cluster_membership_bookkeeper u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .group            (group),
    .target_class     (target_class),
    .feature_bits     (feature_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .previous_class   (previous_class),
    .class_members    (class_members),
    .nonempty_classes (nonempty_classes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Membership shadow. Feature sums never reach the outputs, so only
  // membership and counts are tracked.
  logic [OUT_W-1:0] class_of   [NUM_GROUPS];
  logic [OUT_W-1:0] class_count[NUM_GROUPS];
  logic [OUT_W-1:0] occupied   = '0;
  logic [GIU_W-1:0] groups_cfg = GIU_RESET;

  member_req_t pending_items[$];
  member_rsp_t expected_rsp[$];
  int          mismatches  = 0;
  int          cycle_count = 0;

  initial begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      class_of[g]    = 9'd256;
      class_count[g] = '0;
    end
  end

  function automatic int live_groups();
    return (groups_cfg > NUM_GROUPS) ? NUM_GROUPS : int'(groups_cfg);
  endfunction

  function automatic void leave_class(logic [GROUP_W-1:0] g);
    logic [GROUP_W-1:0] c;
    c = class_of[g][GROUP_W-1:0];
    if (class_count[c] > 0) begin
      class_count[c] = class_count[c] - OUT_W'(1);
      if (class_count[c] == 0 && occupied > 0) occupied = occupied - OUT_W'(1);
    end
    class_of[g] = 9'd256;
  endfunction

  function automatic member_rsp_t apply_membership(member_req_t r);
    member_rsp_t      rsp;
    int               ng;
    logic [OUT_W-1:0] prev;
    logic             assigned;
    ng = live_groups();
    rsp.status           = 1'b0;
    rsp.class_members    = '0;
    if (r.group >= ng || (r.op == OP_MOVE && r.target_class >= ng)) begin
      rsp.status           = 1'b1;
      rsp.previous_class   = 9'd256;
      rsp.nonempty_classes = occupied;
      return rsp;
    end
    prev     = class_of[r.group];
    assigned = (prev < NUM_GROUPS);
    case (r.op)
      OP_MOVE: begin
        if (!(assigned && prev == {1'b0, r.target_class})) begin
          if (assigned) leave_class(r.group);
          if (class_count[r.target_class] == 0) occupied = occupied + OUT_W'(1);
          class_count[r.target_class] = class_count[r.target_class] + OUT_W'(1);
          class_of[r.group] = {1'b0, r.target_class};
        end
        rsp.class_members = class_count[r.target_class];
      end
      OP_REMOVE: begin
        if (assigned) begin
          leave_class(r.group);
          rsp.class_members = class_count[prev[GROUP_W-1:0]];
        end
      end
      // load and the reserved code leave membership alone
      default: rsp.class_members = assigned ? class_count[prev[GROUP_W-1:0]] : '0;
    endcase
    rsp.previous_class   = assigned ? prev : 9'd256;
    rsp.nonempty_classes = occupied;
    return rsp;
  endfunction

  // Sender: bursts of items separated by idle gaps.
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin
    member_req_t nxt;
    logic        holding;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        nxt.op           = op_t'(opcode);
        nxt.group        = group;
        nxt.target_class = target_class;
        nxt.feature_bits = feature_bits;
        expected_rsp.push_back(apply_membership(nxt));
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          opcode       <= nxt.op;
          group        <= nxt.group;
          target_class <= nxt.target_class;
          feature_bits <= nxt.feature_bits;
          in_valid     <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                     : $urandom_range(0, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: picks a new random stall mode whenever its current stretch runs out.
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    member_rsp_t exp_rsp;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          exp_rsp = expected_rsp.pop_front();
          if (status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, status);
            mismatches++;
          end
          if (previous_class !== exp_rsp.previous_class) begin
            $error("previous_class: expected %0d, got %0d",
                   exp_rsp.previous_class, previous_class);
            mismatches++;
          end
          if (class_members !== exp_rsp.class_members) begin
            $error("class_members: expected %0d, got %0d",
                   exp_rsp.class_members, class_members);
            mismatches++;
          end
          if (nonempty_classes !== exp_rsp.nonempty_classes) begin
            $error("nonempty_classes: expected %0d, got %0d",
                   exp_rsp.nonempty_classes, nonempty_classes);
            mismatches++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 80);
      end else begin
        stall_left = stall_left - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cluster_membership_bookkeeper_test failed");
      $finish;
    end
  end

  task automatic push_item(op_t op, int grp, int tgt, logic [BITS_W-1:0] bits);
    member_req_t r;
    r.op           = op;
    r.group        = grp[GROUP_W-1:0];
    r.target_class = tgt[GROUP_W-1:0];
    r.feature_bits = bits;
    pending_items.push_back(r);
  endtask

  // Wait until every item is sent and answered, then let the pipe settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_rsp.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_config(logic [GIU_W-1:0] giu, logic [FIU_W-1:0] fiu);
    cfg_write <= 1'b1;
    cfg_index <= REG_GROUPS;
    cfg_data  <= giu;
    @(posedge clk);
    groups_cfg = giu;
    cfg_index <= REG_FEATURES;
    cfg_data  <= {{(CFG_W-FIU_W){1'b0}}, fiu};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Biased toward a handful of low indices so classes collect members.
  function automatic int pick_index(int ng);
    int lim;
    if (ng == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    lim = (ng < 8) ? ng : 8;
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, lim - 1);
    return $urandom_range(0, ng - 1);
  endfunction

  task automatic add_random(int n);
    int  ng;
    int  roll;
    op_t op;
    ng = live_groups();
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      op = OP_MOVE;
      else if (roll < 65) op = OP_LOAD;
      else if (roll < 92) op = OP_REMOVE;
      else                op = OP_RSVD;
      push_item(op, pick_index(ng), pick_index(ng), $urandom);
    end
  endtask

  logic [GIU_W-1:0] phase_groups[7] = '{9'd256, 9'd1, 9'd16, 9'd511, 9'd3, 9'd0, 9'd200};
  logic [FIU_W-1:0] phase_feats [7] = '{6'd32, 6'd1, 6'd8, 6'd63, 6'd0, 6'd32, 6'd17};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 256 groups, 32 features
    push_item(OP_LOAD,   0,   0,   32'hFFFF_FFFF);
    push_item(OP_LOAD,   255, 255, 32'h0000_0000);
    push_item(OP_REMOVE, 3,   0,   32'h0);          // unassigned group
    push_item(OP_RSVD,   3,   255, 32'h1234_5678);
    push_item(OP_MOVE,   0,   255, 32'h0);
    push_item(OP_MOVE,   0,   255, 32'h0);          // already there
    push_item(OP_MOVE,   1,   255, 32'h0);
    push_item(OP_MOVE,   255, 0,   32'h0);
    push_item(OP_MOVE,   2,   128, 32'h0);
    push_item(OP_LOAD,   0,   0,   32'hA5A5_5A5A);  // load while assigned
    push_item(OP_MOVE,   0,   0,   32'h0);
    push_item(OP_RSVD,   255, 0,   32'hFFFF_FFFF);
    push_item(OP_REMOVE, 0,   0,   32'h0);
    push_item(OP_REMOVE, 0,   0,   32'h0);
    push_item(OP_MOVE,   200, 200, 32'h0);
    drain();

    // shrink to 10 groups: range checks and classes left over from before
    set_config(9'd10, 6'd5);
    push_item(OP_LOAD,   10,  0,   32'h0F0F_0F0F);
    push_item(OP_MOVE,   2,   10,  32'h0);
    push_item(OP_MOVE,   255, 1,   32'h0);
    push_item(OP_MOVE,   1,   2,   32'h0);          // leaves class 255
    push_item(OP_REMOVE, 2,   0,   32'h0);          // leaves class 128
    push_item(OP_RSVD,   9,   255, 32'h0);
    drain();

    // no groups at all: everything out of range
    set_config(9'd0, 6'd0);
    push_item(OP_LOAD,   0, 0, 32'hFFFF_FFFF);
    push_item(OP_RSVD,   0, 0, 32'h0);
    push_item(OP_REMOVE, 0, 0, 32'h0);
    drain();

    for (int p = 0; p < 7; p++) begin
      set_config(phase_groups[p], phase_feats[p]);
      add_random(72);
      drain();
    end

    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("cluster_membership_bookkeeper_test passed");
    end else begin
      $display("cluster_membership_bookkeeper_test failed");
    end
    $finish;
  end

endmodule
